FILE: rtl/core/urb_pkg.sv
`default_nettype none
package urb_pkg;

   // receive fifo geometry
   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // beat field widths
   localparam int OP_W       = 2;
   localparam int IDX_W      = 4;
   localparam int WDATA_W    = 12;
   localparam int BYTE_W     = 8;
   localparam int RDATA_W    = 12;
   localparam int RX_FREE_W  = 5;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_FILL_W  = RSP_TDATA_W - (RDATA_W + 1 + BYTE_W + 1 + RX_FREE_W);

   // operation codes
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_RX    = 2'd2;

   // register word indexes
   localparam logic [IDX_W-1:0] REG_RBR  = 4'd0;
   localparam logic [IDX_W-1:0] REG_IER  = 4'd1;
   localparam logic [IDX_W-1:0] REG_IIR  = 4'd2;
   localparam logic [IDX_W-1:0] REG_LCR  = 4'd3;
   localparam logic [IDX_W-1:0] REG_MCR  = 4'd4;
   localparam logic [IDX_W-1:0] REG_LSR  = 4'd5;
   localparam logic [IDX_W-1:0] REG_MSR  = 4'd6;
   localparam logic [IDX_W-1:0] REG_SPR  = 4'd7;
   localparam logic [IDX_W-1:0] REG_ISR  = 4'd8;
   localparam logic [IDX_W-1:0] REG_UMR  = 4'd9;
   localparam logic [IDX_W-1:0] REG_UACR = 4'd10;

   // interrupt identification codes (low nibble)
   localparam logic [3:0] IIR_NONE  = 4'h1;
   localparam logic [3:0] IIR_LINE  = 4'h6;
   localparam logic [3:0] IIR_RDA   = 4'h4;
   localparam logic [3:0] IIR_TOUT  = 4'hc;
   localparam logic [3:0] IIR_THRE  = 4'h2;
   localparam logic [3:0] IIR_MODEM = 4'h0;

   // register masks
   localparam logic [7:0] IER_MASK = 8'h1f;
   localparam logic [7:0] FCR_MASK = 8'hd9;
   localparam logic [7:0] MCR_MASK = 8'h92;
   localparam logic [7:0] ISR_MASK = 8'h1f;
   localparam logic [7:0] UMR_MASK = 8'h3f;
   localparam logic [7:0] EMPTY_READ = 8'hff;

   // rx trigger levels
   localparam logic [CNT_W-1:0] TRIG_1  = CNT_W'(1);
   localparam logic [CNT_W-1:0] TRIG_4  = CNT_W'(4);
   localparam logic [CNT_W-1:0] TRIG_8  = CNT_W'(8);
   localparam logic [CNT_W-1:0] TRIG_15 = CNT_W'(15);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   reg_index;
      logic [WDATA_W-1:0] write_data;
      logic [BYTE_W-1:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [RDATA_W-1:0]   read_data;
      logic                 tx_valid;
      logic [BYTE_W-1:0]    tx_byte;
      logic                 irq_out;
      logic [RX_FREE_W-1:0] rx_free;
   } rsp_item_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic              flush;
      logic [BYTE_W-1:0] wdata;
   } fifo_ctrl_type;

   // prioritized interrupt identification
   function automatic logic [7:0] iir_code(
      input logic [7:0]       fcr,
      input logic [4:0]       ier,
      input logic             line_err,
      input logic [CNT_W-1:0] count,
      input logic             thr_flag,
      input logic             msr_delta
   );
      logic [7:0]       fb;
      logic [CNT_W-1:0] trig;
      logic [3:0]       code;
      fb = fcr[0] ? 8'hc0 : 8'h00;
      if (!fcr[0]) begin
         trig = TRIG_1;
      end else begin
         unique case (fcr[7:6])
            2'd0:    trig = TRIG_1;
            2'd1:    trig = TRIG_4;
            2'd2:    trig = TRIG_8;
            default: trig = TRIG_15;
         endcase
      end
      priority if (!fcr[4]) begin
         code = IIR_NONE;
      end else if (ier[2] && line_err) begin
         code = IIR_LINE;
      end else if (ier[0] && (count >= trig)) begin
         code = IIR_RDA;
      end else if (ier[4] && (count != '0)) begin
         code = IIR_TOUT;
      end else if (thr_flag && ier[1]) begin
         code = IIR_THRE;
      end else if (ier[3] && msr_delta) begin
         code = IIR_MODEM;
      end else begin
         code = IIR_NONE;
      end
      return fb | {4'h0, code};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/uart_16550_register_bank_top.sv
// channel   dir  beat fields (lowest bit up)
// req       in   tuser: op | tdata: reg_index, write_data, rx_byte
// rsp       out  tdata: read_data, tx_valid, tx_byte, irq_out, rx_free
//
// one beat per cycle sustained while rsp_tready is high; a beat is registered in
// the input register, is applied to the register bank on its way into the
// result register, and the result register drives rsp
// reset is synchronous and clears both stage valid bits and all control registers
// a stalled result holds the input stage; req_tready means it is empty or advancing
`default_nettype none
module uart_16550_register_bank_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [urb_pkg::OP_W-1:0]          req_tuser,  // op
   input  wire logic [urb_pkg::REQ_TDATA_W-1:0]   req_tdata,  // reg_index, write_data, rx_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // read_data, tx_valid, tx_byte, irq_out, rx_free, zero fill
   output logic [urb_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   // input stage
   logic                    in_valid_ff, in_valid_in;
   urb_pkg::req_item_type   in_item_ff;
   // result stage
   logic                    out_valid_ff, out_valid_in;
   urb_pkg::rsp_item_type   out_item_ff;

   logic                    accept;
   logic                    advance;
   urb_pkg::req_item_type   req_item;
   urb_pkg::rsp_item_type   rsp_item;
   urb_pkg::fifo_ctrl_type  fifo_ctrl;
   logic [urb_pkg::CNT_W-1:0]  fifo_count;
   logic [urb_pkg::BYTE_W-1:0] fifo_head_data;

   // unpack the request beat
   assign req_item.op         = req_tuser;
   assign req_item.reg_index  = req_tdata[3:0];
   assign req_item.write_data = req_tdata[15:4];
   assign req_item.rx_byte    = req_tdata[23:16];

   // the held beat moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= rsp_item;
      end
   end

   // register bank state and next-state decode
   urb_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (in_item_ff),
      .fifo_count     (fifo_count),
      .fifo_head_data (fifo_head_data),
      .fifo_ctrl      (fifo_ctrl),
      .rsp            (rsp_item)
   );

   // receive fifo storage and pointers
   urb_rx_fifo u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .count     (fifo_count),
      .head_data (fifo_head_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {urb_pkg::RSP_FILL_W'(0), out_item_ff.rx_free, out_item_ff.irq_out,
                        out_item_ff.tx_byte, out_item_ff.tx_valid, out_item_ff.read_data};

endmodule
`default_nettype wire

FILE: rtl/core/urb_rx_fifo.sv
`default_nettype none
module urb_rx_fifo (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire urb_pkg::fifo_ctrl_type       ctrl,
   output logic [urb_pkg::CNT_W-1:0]         count,
   output logic [urb_pkg::BYTE_W-1:0]        head_data
);

   logic [urb_pkg::BYTE_W-1:0] store_ff [urb_pkg::FIFO_DEPTH];
   logic [urb_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [urb_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [urb_pkg::CNT_W:0]    wr_sum;
   logic [urb_pkg::PTR_W-1:0]  wr_addr;

   // tail slot, wrapped around the depth
   always_comb begin
      wr_sum = {1'b0, count_ff} + (urb_pkg::CNT_W + 1)'(head_ff);
      if (wr_sum >= (urb_pkg::CNT_W + 1)'(urb_pkg::FIFO_DEPTH)) begin
         wr_addr = urb_pkg::PTR_W'(wr_sum - (urb_pkg::CNT_W + 1)'(urb_pkg::FIFO_DEPTH));
      end else begin
         wr_addr = urb_pkg::PTR_W'(wr_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (ctrl.flush) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         head_in  = (head_ff == urb_pkg::PTR_W'(urb_pkg::FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else begin
         head_in  = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.flush) begin
         store_ff[wr_addr] <= ctrl.wdata;
      end
   end

   assign count     = count_ff;
   assign head_data = store_ff[head_ff];

endmodule
`default_nettype wire

FILE: rtl/core/urb_core.sv
`default_nettype none
module urb_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire urb_pkg::req_item_type        item,
   input  wire logic [urb_pkg::CNT_W-1:0]    fifo_count,
   input  wire logic [urb_pkg::BYTE_W-1:0]   fifo_head_data,
   output urb_pkg::fifo_ctrl_type            fifo_ctrl,
   output urb_pkg::rsp_item_type             rsp
);

   logic [4:0]  ier_ff, ier_in;
   logic [7:0]  fcr_ff, fcr_in;
   logic [7:0]  lcr_ff, lcr_in;
   logic [7:0]  mcr_ff, mcr_in;
   logic        cts_ff, cts_in;
   logic        delta_ff, delta_in;
   logic [7:0]  spr_ff, spr_in;
   logic [4:0]  isr_ff, isr_in;
   logic [5:0]  umr_ff, umr_in;
   logic [11:0] uacr_ff, uacr_in;
   logic [7:0]  dll_ff, dll_in;
   logic [7:0]  dlh_ff, dlh_in;
   logic        over_ff, over_in;
   logic        fifoe_ff, fifoe_in;
   logic        thr_ff, thr_in;

   logic                          dlab;
   logic [7:0]                    wbyte;
   logic [7:0]                    iir_now;
   logic [7:0]                    iir_next;
   logic                          cts_new;
   logic                          push, push_ok, pop, flush;
   logic [urb_pkg::BYTE_W-1:0]    push_data;
   logic [urb_pkg::RDATA_W-1:0]   rd;
   logic                          txv;
   logic [urb_pkg::BYTE_W-1:0]    txb;
   logic [urb_pkg::CNT_W-1:0]     count_next;
   logic                          not_empty;

   assign dlab      = lcr_ff[7];
   assign wbyte     = item.write_data[7:0];
   assign not_empty = (fifo_count != '0);
   assign iir_now   = urb_pkg::iir_code(fcr_ff, ier_ff, over_ff | fifoe_ff, fifo_count,
                                        thr_ff, delta_ff);

   always_comb begin
      ier_in    = ier_ff;
      fcr_in    = fcr_ff;
      lcr_in    = lcr_ff;
      mcr_in    = mcr_ff;
      cts_in    = cts_ff;
      delta_in  = delta_ff;
      spr_in    = spr_ff;
      isr_in    = isr_ff;
      umr_in    = umr_ff;
      uacr_in   = uacr_ff;
      dll_in    = dll_ff;
      dlh_in    = dlh_ff;
      over_in   = over_ff;
      fifoe_in  = fifoe_ff;
      thr_in    = thr_ff;
      push      = 1'b0;
      pop       = 1'b0;
      flush     = 1'b0;
      push_data = item.rx_byte;
      rd        = '0;
      txv       = 1'b0;
      txb       = '0;
      cts_new   = 1'b0;

      unique case (item.op)
         urb_pkg::OP_READ: begin
            unique case (item.reg_index)
               urb_pkg::REG_RBR: begin
                  if (dlab) begin
                     rd = 12'(dll_ff);
                  end else if (not_empty) begin
                     rd  = 12'(fifo_head_data);
                     pop = 1'b1;
                  end else begin
                     rd = 12'(urb_pkg::EMPTY_READ);
                  end
               end
               urb_pkg::REG_IER: rd = dlab ? 12'(dlh_ff) : 12'(ier_ff);
               urb_pkg::REG_IIR: begin
                  rd = 12'(iir_now);
                  // reading the thre code drops the latched interrupt
                  if (iir_now[3:0] == urb_pkg::IIR_THRE) begin
                     thr_in = 1'b0;
                  end
               end
               urb_pkg::REG_LCR: rd = 12'(lcr_ff);
               urb_pkg::REG_MCR: rd = 12'(mcr_ff);
               urb_pkg::REG_LSR: begin
                  rd       = 12'({fifoe_ff, 2'b11, 3'b000, over_ff, not_empty});
                  over_in  = 1'b0;
                  fifoe_in = 1'b0;
               end
               urb_pkg::REG_MSR: begin
                  cts_new  = (mcr_ff == urb_pkg::MCR_MASK);
                  rd       = 12'({3'b000, cts_new, 3'b000, delta_ff | (cts_new != cts_ff)});
                  cts_in   = cts_new;
                  delta_in = 1'b0;
               end
               urb_pkg::REG_SPR:  rd = 12'(spr_ff);
               urb_pkg::REG_ISR:  rd = 12'(isr_ff);
               urb_pkg::REG_UMR:  rd = 12'(umr_ff);
               urb_pkg::REG_UACR: rd = uacr_ff;
               default:           rd = '0;
            endcase
         end
         urb_pkg::OP_WRITE: begin
            unique case (item.reg_index)
               urb_pkg::REG_RBR: begin
                  if (dlab) begin
                     dll_in = wbyte;
                  end else begin
                     // cleared by the write, then latched again if enabled
                     thr_in = fcr_ff[4] & ier_ff[1];
                     if (mcr_ff[4]) begin
                        push      = 1'b1;
                        push_data = wbyte;
                     end else begin
                        txv = 1'b1;
                        txb = wbyte;
                     end
                  end
               end
               urb_pkg::REG_IER: begin
                  if (dlab) begin
                     dlh_in = wbyte;
                  end else begin
                     ier_in = 5'(wbyte & urb_pkg::IER_MASK);
                     if (!wbyte[1]) begin
                        thr_in = 1'b0;
                     end else if (!ier_ff[1] && fcr_ff[4]) begin
                        thr_in = 1'b1;
                     end
                  end
               end
               urb_pkg::REG_IIR: begin
                  if (wbyte[1]) begin
                     flush    = 1'b1;
                     over_in  = 1'b0;
                     fifoe_in = 1'b0;
                  end
                  if (wbyte[2]) begin
                     thr_in = 1'b0;
                  end
                  fcr_in = wbyte & urb_pkg::FCR_MASK;
                  if (!wbyte[4]) begin
                     thr_in = 1'b0;
                  end else if (ier_ff[1]) begin
                     thr_in = 1'b1;
                  end
               end
               urb_pkg::REG_LCR: lcr_in = wbyte;
               urb_pkg::REG_MCR: begin
                  mcr_in  = wbyte & urb_pkg::MCR_MASK;
                  cts_new = ((wbyte & urb_pkg::MCR_MASK) == urb_pkg::MCR_MASK);
                  cts_in  = cts_new;
                  if (cts_new != cts_ff) begin
                     delta_in = 1'b1;
                  end
               end
               urb_pkg::REG_SPR:  spr_in  = wbyte;
               urb_pkg::REG_ISR:  isr_in  = 5'(wbyte & urb_pkg::ISR_MASK);
               urb_pkg::REG_UMR:  umr_in  = 6'(wbyte & urb_pkg::UMR_MASK);
               urb_pkg::REG_UACR: uacr_in = item.write_data;
               default: ;
            endcase
         end
         urb_pkg::OP_RX: push = 1'b1;
         default: ;
      endcase

      // a full fifo drops the byte and flags overrun
      push_ok = push && (fifo_count != urb_pkg::CNT_W'(urb_pkg::FIFO_DEPTH));
      if (push && !push_ok) begin
         over_in = 1'b1;
      end
      // fifo error summary is sticky once overrun is seen in fifo mode
      fifoe_in = fifoe_in | (fcr_in[0] & over_in);

      priority if (flush) begin
         count_next = '0;
      end else if (push_ok) begin
         count_next = fifo_count + 1'b1;
      end else if (pop) begin
         count_next = fifo_count - 1'b1;
      end else begin
         count_next = fifo_count;
      end
   end

   assign iir_next = urb_pkg::iir_code(fcr_in, ier_in, over_in | fifoe_in, count_next,
                                       thr_in, delta_in);

   assign fifo_ctrl.push  = step & push_ok;
   assign fifo_ctrl.pop   = step & pop;
   assign fifo_ctrl.flush = step & flush;
   assign fifo_ctrl.wdata = push_data;

   assign rsp.read_data = rd;
   assign rsp.tx_valid  = txv;
   assign rsp.tx_byte   = txb;
   assign rsp.irq_out   = ~iir_next[0];
   assign rsp.rx_free   = urb_pkg::RX_FREE_W'(urb_pkg::CNT_W'(urb_pkg::FIFO_DEPTH) - count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         ier_ff   <= '0;
         fcr_ff   <= '0;
         lcr_ff   <= '0;
         mcr_ff   <= '0;
         cts_ff   <= 1'b0;
         delta_ff <= 1'b0;
         spr_ff   <= '0;
         isr_ff   <= '0;
         umr_ff   <= '0;
         uacr_ff  <= '0;
         dll_ff   <= '0;
         dlh_ff   <= '0;
         over_ff  <= 1'b0;
         fifoe_ff <= 1'b0;
         thr_ff   <= 1'b0;
      end else if (step) begin
         ier_ff   <= ier_in;
         fcr_ff   <= fcr_in;
         lcr_ff   <= lcr_in;
         mcr_ff   <= mcr_in;
         cts_ff   <= cts_in;
         delta_ff <= delta_in;
         spr_ff   <= spr_in;
         isr_ff   <= isr_in;
         umr_ff   <= umr_in;
         uacr_ff  <= uacr_in;
         dll_ff   <= dll_in;
         dlh_ff   <= dlh_in;
         over_ff  <= over_in;
         fifoe_ff <= fifoe_in;
         thr_ff   <= thr_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/urb_checker.sv
`default_nettype none
module urb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [urb_pkg::OP_W-1:0]          req_tuser,
   input wire logic [urb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [urb_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic req_beat;
   assign req_beat = req_tvalid & req_tready & (req_tuser != urb_pkg::OP_READ) & (req_tdata != '0);

   // result stage empties after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // free space never exceeds the fifo depth
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:22] <= urb_pkg::RX_FREE_W'(urb_pkg::FIFO_DEPTH))
      else $error("rx free space out of range");

   // no transmit means a zero byte
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[12] |-> rsp_tdata[20:13] == '0)
      else $error("tx byte set without tx valid");

   // a transmit comes from a write, which returns no read data
   a_tx_no_read: assert property (@(posedge clock) disable iff (reset || req_beat)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[11:0] == '0)
      else $error("read data alongside a transmitted byte");

endmodule

bind uart_16550_register_bank_top urb_checker u_checker (.*);
`default_nettype wire

FILE: bench/uart_16550_register_bank_top_tb.sv
`timescale 1ns / 1ps
module uart_16550_register_bank_top_tb;
   import urb_pkg::*;

   // op value with no meaning, and indexes past the last register
   localparam logic [OP_W-1:0]  OP_IDLE   = 2'd3;
   localparam logic [IDX_W-1:0] REG_SPARE = 4'd11;
   localparam logic [IDX_W-1:0] REG_LAST  = 4'd15;

   // line status bits
   localparam logic [7:0] LSR_DR       = 8'h01;
   localparam logic [7:0] LSR_OE       = 8'h02;
   localparam logic [7:0] LSR_RX_ERRS  = 8'h1e;
   localparam logic [7:0] LSR_THRE     = 8'h20;
   localparam logic [7:0] LSR_IDLE     = 8'h60;
   localparam logic [7:0] LSR_FIFO_ERR = 8'h80;
   localparam logic [7:0] LSR_STICKY   = 8'h9e;

   localparam int RANDOM_BEATS = 1250;
   localparam int CALM_FIRST   = 500;
   localparam int CALM_LAST    = 700;
   localparam int IDLE_PCT     = 35;
   localparam int TAIL_CYCLES  = 10;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      req_item_type beat;
      int unsigned  reps;
      bit           typed;
      rsp_item_type want;
   } plan_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser  = '0;  // op
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // reg_index, write_data, rx_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // read_data, tx_valid, tx_byte, irq_out, rx_free, zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // no idling on either side while this is set
   bit calm = 1'b0;

   rsp_item_type expected_rsp [$];
   int unsigned  mismatches   = 0;
   int unsigned  stall_cycles = 0;

   // shadow copy of the register bank
   logic [7:0]       rxq_mem [FIFO_DEPTH];
   logic [PTR_W-1:0] rxq_head;
   logic [CNT_W-1:0] rxq_count;
   logic [7:0]       lsr_q;
   logic             thre_latch;
   logic [4:0]       ier_q;
   logic [7:0]       fcr_q;
   logic [7:0]       lcr_q;
   logic [7:0]       mcr_q;
   logic [7:0]       msr_q;
   logic [7:0]       spr_q;
   logic [4:0]       isr_q;
   logic [5:0]       umr_q;
   logic [11:0]      uacr_q;
   logic [7:0]       dll_q;
   logic [7:0]       dlh_q;

   uart_16550_register_bank_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // shadow bank behavior
   // ---------------------------------------------------------------

   // interrupt identification in priority order, fifo bits on top
   function automatic logic [7:0] iir_now();
      logic [7:0]       fb;
      logic [CNT_W-1:0] trig;
      logic [3:0]       code;
      fb = fcr_q[0] ? 8'hc0 : 8'h00;
      case (fcr_q[7:6])
         2'd0:    trig = CNT_W'(1);
         2'd1:    trig = CNT_W'(4);
         2'd2:    trig = CNT_W'(8);
         default: trig = CNT_W'(15);
      endcase
      // trigger levels only apply with the fifo enabled
      if (!fcr_q[0]) trig = CNT_W'(1);
      if (!fcr_q[4]) begin
         code = IIR_NONE;
      end else if (ier_q[2] && (lsr_q & LSR_STICKY) != 0) begin
         code = IIR_LINE;
      end else if (ier_q[0] && rxq_count >= trig) begin
         code = IIR_RDA;
      end else if (ier_q[4] && rxq_count != 0) begin
         code = IIR_TOUT;
      end else if (thre_latch && ier_q[1] && (lsr_q & LSR_THRE) != 0) begin
         code = IIR_THRE;
      end else if (ier_q[3] && msr_q[0]) begin
         code = IIR_MODEM;
      end else begin
         code = IIR_NONE;
      end
      return fb | {4'h0, code};
   endfunction

   // rebuild lsr from its sticky bits and the fifo fill
   task automatic lsr_update();
      logic [7:0] sticky;
      logic [7:0] nv;
      sticky = lsr_q & LSR_STICKY;
      nv = sticky | LSR_IDLE;
      if (rxq_count != 0) nv = nv | LSR_DR;
      if (fcr_q[0] && (sticky & LSR_RX_ERRS) != 0) nv = nv | LSR_FIFO_ERR;
      lsr_q = nv;
   endtask

   // latch the transmit-empty interrupt when it is enabled
   task automatic thre_arm();
      if (fcr_q[4] && ier_q[1] && (lsr_q & LSR_THRE) != 0) thre_latch = 1'b1;
   endtask

   task automatic rxq_push(input logic [7:0] b);
      if (rxq_count < FIFO_DEPTH) begin
         rxq_mem[PTR_W'(rxq_head + rxq_count)] = b;
         rxq_count = rxq_count + 1'b1;
      end else begin
         // full fifo drops the byte and flags overrun
         lsr_q = lsr_q | LSR_OE;
      end
      lsr_update();
   endtask

   // cts follows the masked mcr bits, delta flag on any change
   task automatic msr_update();
      logic old_cts;
      logic cts;
      old_cts = msr_q[4];
      cts = ((mcr_q & MCR_MASK) == MCR_MASK);
      msr_q = {3'b000, cts, 3'b000, msr_q[0]};
      if (old_cts != cts) msr_q[0] = 1'b1;
   endtask

   // apply one accepted beat to the shadow bank and work out its result
   task automatic predict_beat(input req_item_type b, output rsp_item_type r);
      logic [11:0] rd;
      logic        txv;
      logic [7:0]  txb;
      logic [7:0]  v;
      logic        dlab;
      logic        had_thre_en;
      logic [7:0]  iir;
      rd = '0;
      txv = 1'b0;
      txb = '0;
      v = b.write_data[7:0];
      dlab = lcr_q[7];
      case (b.op)
         OP_READ: begin
            case (b.reg_index)
               REG_RBR: begin
                  if (dlab) begin
                     rd = {4'h0, dll_q};
                  end else begin
                     if (rxq_count != 0) begin
                        rd = {4'h0, rxq_mem[rxq_head]};
                        rxq_head = rxq_head + 1'b1;
                        rxq_count = rxq_count - 1'b1;
                     end else begin
                        rd = {4'h0, EMPTY_READ};
                     end
                     lsr_update();
                  end
               end
               REG_IER: rd = dlab ? {4'h0, dlh_q} : {7'h0, ier_q};
               REG_IIR: begin
                  rd = {4'h0, iir_now()};
                  // reading the transmit-empty code acknowledges it
                  if (rd[3:0] == IIR_THRE) thre_latch = 1'b0;
               end
               REG_LCR: rd = {4'h0, lcr_q};
               REG_MCR: rd = {4'h0, mcr_q};
               REG_LSR: begin
                  lsr_update();
                  rd = {4'h0, lsr_q};
                  lsr_q = lsr_q & ~LSR_STICKY;
                  lsr_update();
               end
               REG_MSR: begin
                  msr_update();
                  rd = {4'h0, msr_q};
                  msr_q[0] = 1'b0;
               end
               REG_SPR:  rd = {4'h0, spr_q};
               REG_ISR:  rd = {7'h0, isr_q};
               REG_UMR:  rd = {6'h0, umr_q};
               REG_UACR: rd = uacr_q;
               default:  rd = '0;
            endcase
         end
         OP_WRITE: begin
            case (b.reg_index)
               REG_RBR: begin
                  if (dlab) begin
                     dll_q = v;
                  end else begin
                     thre_latch = 1'b0;
                     // loopback turns the transmitted byte into a received one
                     if (mcr_q[4]) begin
                        rxq_push(v);
                     end else begin
                        txv = 1'b1;
                        txb = v;
                     end
                     lsr_update();
                     thre_arm();
                  end
               end
               REG_IER: begin
                  if (dlab) begin
                     dlh_q = v;
                  end else begin
                     had_thre_en = ier_q[1];
                     ier_q = v[4:0];
                     if (!ier_q[1]) thre_latch = 1'b0;
                     else if (!had_thre_en) thre_arm();
                  end
               end
               REG_IIR: begin
                  if (v[1]) begin
                     rxq_head = '0;
                     rxq_count = '0;
                     lsr_q = lsr_q & ~LSR_STICKY;
                     lsr_update();
                  end
                  if (v[2]) thre_latch = 1'b0;
                  fcr_q = v & FCR_MASK;
                  if (fcr_q[4]) thre_arm();
                  else thre_latch = 1'b0;
               end
               REG_LCR: lcr_q = v;
               REG_MCR: begin
                  mcr_q = v & MCR_MASK;
                  msr_update();
               end
               REG_SPR:  spr_q = v;
               REG_ISR:  isr_q = v[4:0] & ISR_MASK[4:0];
               REG_UMR:  umr_q = v[5:0] & UMR_MASK[5:0];
               REG_UACR: uacr_q = b.write_data;
               default: ;
            endcase
            lsr_update();
         end
         OP_RX: rxq_push(b.rx_byte);
         default: ;
      endcase
      iir = iir_now();
      r.read_data = rd;
      r.tx_valid  = txv;
      r.tx_byte   = txv ? txb : 8'h00;
      r.irq_out   = ~iir[0];
      r.rx_free   = RX_FREE_W'(FIFO_DEPTH - rxq_count);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   function automatic plan_row_type row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                        input logic [11:0] wd, input logic [7:0] rb,
                                        input int unsigned reps, input bit typed,
                                        input rsp_item_type want);
      plan_row_type p;
      p.beat.op         = op;
      p.beat.reg_index  = idx;
      p.beat.write_data = wd;
      p.beat.rx_byte    = rb;
      p.reps            = reps;
      p.typed           = typed;
      p.want            = want;
      return p;
   endfunction

   function automatic rsp_item_type fixed_rsp(input logic [11:0] rd, input logic txv,
                                              input logic [7:0] txb, input logic irq,
                                              input logic [4:0] free);
      rsp_item_type r;
      r.read_data = rd;
      r.tx_valid  = txv;
      r.tx_byte   = txb;
      r.irq_out   = irq;
      r.rx_free   = free;
      return r;
   endfunction

   // present one beat, wait for its handshake, then log what it should return
   task automatic send_beat(input req_item_type b, input bit typed, input rsp_item_type want);
      rsp_item_type pred;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.op;
      req_tdata  <= {b.rx_byte, b.write_data, b.reg_index};
      do @(posedge clock); while (!req_tready);
      predict_beat(b, pred);
      expected_rsp.push_back(typed ? want : pred);
   endtask

   initial begin : stimulus
      plan_row_type plan [$];
      rsp_item_type none;
      req_item_type b;
      int unsigned  pick;
      none = '0;

      // shadow bank starts from its reset state
      foreach (rxq_mem[i]) rxq_mem[i] = '0;
      rxq_head   = '0;
      rxq_count  = '0;
      lsr_q      = LSR_IDLE;
      thre_latch = 1'b0;
      ier_q      = '0;
      fcr_q      = '0;
      lcr_q      = '0;
      mcr_q      = '0;
      msr_q      = '0;
      spr_q      = '0;
      isr_q      = '0;
      umr_q      = '0;
      uacr_q     = '0;
      dll_q      = '0;
      dlh_q      = '0;

      // values straight after reset, empty fifo read, unused index and op
      plan.push_back(row(OP_READ,  REG_LSR,  12'h000, 8'h00, 1, 1,
                         fixed_rsp(12'h060, 1'b0, 8'h00, 1'b0, 5'd16)));
      plan.push_back(row(OP_READ,  REG_RBR,  12'h000, 8'h00, 1, 1,
                         fixed_rsp(12'h0ff, 1'b0, 8'h00, 1'b0, 5'd16)));
      plan.push_back(row(OP_READ,  REG_LAST, 12'hfff, 8'hff, 1, 1,
                         fixed_rsp(12'h000, 1'b0, 8'h00, 1'b0, 5'd16)));
      plan.push_back(row(OP_IDLE,  REG_RBR,  12'hfff, 8'hff, 1, 1,
                         fixed_rsp(12'h000, 1'b0, 8'h00, 1'b0, 5'd16)));
      // extremes: transmit all ones, full-width uacr round trip
      plan.push_back(row(OP_WRITE, REG_RBR,  12'hfff, 8'h00, 1, 1,
                         fixed_rsp(12'h000, 1'b1, 8'hff, 1'b0, 5'd16)));
      plan.push_back(row(OP_WRITE, REG_UACR, 12'hfff, 8'h00, 1, 1,
                         fixed_rsp(12'h000, 1'b0, 8'h00, 1'b0, 5'd16)));
      plan.push_back(row(OP_READ,  REG_UACR, 12'h000, 8'h00, 1, 1,
                         fixed_rsp(12'hfff, 1'b0, 8'h00, 1'b0, 5'd16)));
      // loopback with cts, fifo on, every interrupt enabled
      plan.push_back(row(OP_WRITE, REG_MCR,  12'h0ff, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_IIR,  12'h017, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_IER,  12'h01f, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_RBR,  12'h03c, 8'h00, 1, 0, none));
      plan.push_back(row(OP_READ,  REG_MSR,  12'h000, 8'h00, 1, 0, none));
      plan.push_back(row(OP_READ,  REG_IIR,  12'h000, 8'h00, 1, 0, none));
      // highest trigger level, then fill the fifo and overrun it
      plan.push_back(row(OP_WRITE, REG_IIR,  12'h0d1, 8'h00, 1, 0, none));
      plan.push_back(row(OP_RX,    REG_RBR,  12'h000, 8'h00, 8, 0, none));
      plan.push_back(row(OP_RX,    REG_RBR,  12'h000, 8'hff, 8, 0, none));
      plan.push_back(row(OP_READ,  REG_IIR,  12'h000, 8'h00, 1, 0, none));
      plan.push_back(row(OP_READ,  REG_LSR,  12'h000, 8'h00, 1, 0, none));
      plan.push_back(row(OP_READ,  REG_RBR,  12'h000, 8'h00, 2, 0, none));
      // writes that must be ignored
      plan.push_back(row(OP_WRITE, REG_LSR,  12'hfff, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_MSR,  12'hfff, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_SPARE, 12'hfff, 8'h00, 1, 0, none));
      // divisor latches behind dlab
      plan.push_back(row(OP_WRITE, REG_LCR,  12'h080, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_RBR,  12'h000, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_IER,  12'h0ff, 8'h00, 1, 0, none));
      plan.push_back(row(OP_READ,  REG_IER,  12'h000, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_LCR,  12'h000, 8'h00, 1, 0, none));
      plan.push_back(row(OP_WRITE, REG_MCR,  12'h000, 8'h00, 1, 0, none));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int unsigned n = 0; n < plan[i].reps; n++) begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
         end
      end

      // random traffic weighted toward fifo fill and drain, with control writes
      // kept mostly sane (dlab and flush off most of the time, iir enabled)
      for (int k = 0; k < RANDOM_BEATS; k++) begin
         calm = (k >= CALM_FIRST && k < CALM_LAST);
         b.op         = OP_READ;
         b.reg_index  = IDX_W'($urandom_range(0, 15));
         b.write_data = WDATA_W'($urandom_range(0, 4095));
         b.rx_byte    = BYTE_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            b.op = OP_RX;
         end else if (pick < 45) begin
            b.reg_index = REG_RBR;
         end else if (pick < 55) begin
            b.op = OP_WRITE;
            b.reg_index = REG_RBR;
         end else if (pick < 65) begin
            case ($urandom_range(0, 2))
               0:       b.reg_index = REG_IIR;
               1:       b.reg_index = REG_LSR;
               default: b.reg_index = REG_MSR;
            endcase
         end else if (pick < 85) begin
            b.op = OP_WRITE;
            b.reg_index = IDX_W'($urandom_range(0, 10));
            if (b.reg_index == REG_LCR && $urandom_range(0, 3) != 0)
               b.write_data[7] = 1'b0;
            if (b.reg_index == REG_IIR) begin
               if ($urandom_range(0, 3) != 0) b.write_data[1] = 1'b0;
               if ($urandom_range(0, 3) != 0) b.write_data[4] = 1'b1;
            end
         end else if (pick < 93) begin
            b.op = OP_READ;
         end else if (pick < 97) begin
            b.op = OP_WRITE;
         end else begin
            b.op = OP_IDLE;
         end
         send_beat(b, 1'b0, none);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // receiver stalls at random, except inside the calm window
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_data = rsp_tdata[11:0];
         got.tx_valid  = rsp_tdata[12];
         got.tx_byte   = rsp_tdata[20:13];
         got.irq_out   = rsp_tdata[21];
         got.rx_free   = rsp_tdata[26:22];
         if (expected_rsp.size() == 0) begin
            report_mismatch("beat with nothing pending", rsp_tdata, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (got.read_data != want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
            if (got.tx_valid != want.tx_valid)
               report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte != want.tx_byte)
               report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
            if (got.irq_out != want.irq_out)
               report_mismatch("irq_out", got.irq_out, want.irq_out);
            if (got.rx_free != want.rx_free)
               report_mismatch("rx_free", got.rx_free, want.rx_free);
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
